/* rtl/ps2s1_pkg.sv */
// Shared constants and the character lookup for the set 1 scan-code decoder.
package ps2s1_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned IdxW  = 6;

  // Scan-code values
  localparam logic [ByteW-1:0] PrefixByte = 8'hE0;
  localparam logic [ByteW-1:0] RomLimit   = 8'h3B;
  localparam logic [ByteW-1:0] MkShiftL   = 8'h2A;
  localparam logic [ByteW-1:0] MkShiftR   = 8'h36;
  localparam logic [ByteW-1:0] MkAltL     = 8'h38;
  localparam logic [ByteW-1:0] MkCtrlL    = 8'h1D;
  localparam logic [ByteW-1:0] MkCaps     = 8'h3A;

  // Keys whose upper character depends on shift alone (digits, punctuation)
  function automatic logic is_symbol_key(input logic [ByteW-1:0] code);
    logic hit;
    begin
      hit = (code < 8'h0E) || (code == 8'h29) || (code == 8'h1A) ||
            (code == 8'h1B) || (code == 8'h2B) || (code == 8'h27) ||
            (code == 8'h28) || (code == 8'h33) || (code == 8'h34) ||
            (code == 8'h35);
      return hit;
    end
  endfunction

  // Character ROM: lower and upper character per make code, zero for none
  function automatic logic [CharW-1:0] char_lookup(input logic [IdxW-1:0] idx,
                                                   input logic            up);
    logic [CharW-1:0] lo;
    logic [CharW-1:0] hi;
    begin
      lo = '0;
      hi = '0;
      unique case (idx)
        6'h01: begin lo = 7'h1B; hi = 7'h1B; end
        6'h02: begin lo = 7'h31; hi = 7'h21; end
        6'h03: begin lo = 7'h32; hi = 7'h40; end
        6'h04: begin lo = 7'h33; hi = 7'h23; end
        6'h05: begin lo = 7'h34; hi = 7'h24; end
        6'h06: begin lo = 7'h35; hi = 7'h25; end
        6'h07: begin lo = 7'h36; hi = 7'h5E; end
        6'h08: begin lo = 7'h37; hi = 7'h26; end
        6'h09: begin lo = 7'h38; hi = 7'h2A; end
        6'h0A: begin lo = 7'h39; hi = 7'h28; end
        6'h0B: begin lo = 7'h30; hi = 7'h29; end
        6'h0C: begin lo = 7'h2D; hi = 7'h5F; end
        6'h0D: begin lo = 7'h3D; hi = 7'h2B; end
        6'h0E: begin lo = 7'h08; hi = 7'h08; end
        6'h0F: begin lo = 7'h09; hi = 7'h09; end
        6'h10: begin lo = 7'h71; hi = 7'h51; end
        6'h11: begin lo = 7'h77; hi = 7'h57; end
        6'h12: begin lo = 7'h65; hi = 7'h45; end
        6'h13: begin lo = 7'h72; hi = 7'h52; end
        6'h14: begin lo = 7'h74; hi = 7'h54; end
        6'h15: begin lo = 7'h79; hi = 7'h59; end
        6'h16: begin lo = 7'h75; hi = 7'h55; end
        6'h17: begin lo = 7'h69; hi = 7'h49; end
        6'h18: begin lo = 7'h6F; hi = 7'h4F; end
        6'h19: begin lo = 7'h70; hi = 7'h50; end
        6'h1A: begin lo = 7'h5B; hi = 7'h7B; end
        6'h1B: begin lo = 7'h5D; hi = 7'h7D; end
        6'h1C: begin lo = 7'h0D; hi = 7'h0D; end
        6'h1E: begin lo = 7'h61; hi = 7'h41; end
        6'h1F: begin lo = 7'h73; hi = 7'h53; end
        6'h20: begin lo = 7'h64; hi = 7'h44; end
        6'h21: begin lo = 7'h66; hi = 7'h46; end
        6'h22: begin lo = 7'h67; hi = 7'h47; end
        6'h23: begin lo = 7'h68; hi = 7'h48; end
        6'h24: begin lo = 7'h6A; hi = 7'h4A; end
        6'h25: begin lo = 7'h6B; hi = 7'h4B; end
        6'h26: begin lo = 7'h6C; hi = 7'h4C; end
        6'h27: begin lo = 7'h3B; hi = 7'h3A; end
        6'h28: begin lo = 7'h27; hi = 7'h22; end
        6'h29: begin lo = 7'h60; hi = 7'h7E; end
        6'h2B: begin lo = 7'h5C; hi = 7'h7C; end
        6'h2C: begin lo = 7'h7A; hi = 7'h5A; end
        6'h2D: begin lo = 7'h78; hi = 7'h58; end
        6'h2E: begin lo = 7'h63; hi = 7'h43; end
        6'h2F: begin lo = 7'h76; hi = 7'h56; end
        6'h30: begin lo = 7'h62; hi = 7'h42; end
        6'h31: begin lo = 7'h6E; hi = 7'h4E; end
        6'h32: begin lo = 7'h6D; hi = 7'h4D; end
        6'h33: begin lo = 7'h2C; hi = 7'h3C; end
        6'h34: begin lo = 7'h2E; hi = 7'h3E; end
        6'h35: begin lo = 7'h2F; hi = 7'h3F; end
        6'h37: begin lo = 7'h2A; hi = 7'h2A; end
        6'h39: begin lo = 7'h20; hi = 7'h20; end
        default: begin lo = '0; hi = '0; end
      endcase
      return up ? hi : lo;
    end
  endfunction

endpackage

/* rtl/ps2_set1_scancode_decoder.sv */
// Top level: set 1 scan-code to ASCII decoder with modifier tracking.
//
// Takes one raw scan-code byte per word and returns one result word per byte:
// the ASCII character (with char_valid_o), an unknown-code flag and the ctrl,
// shift, alt and caps-lock state after the byte. A byte passes through an
// input register and one stage of table lookup into the result register, and
// a byte can be taken every cycle while the result is not stalled; the input
// register can take and hold one byte while a finished result waits on out_stall_i.
// An E0 prefix byte produces a result word with no character and no flag.
module ps2_set1_scancode_decoder
  import ps2s1_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] scan_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] char_code_o,
  output logic             char_valid_o,
  output logic             unknown_code_o,
  output logic             ctrl_down_o,
  output logic             shift_down_o,
  output logic             alt_down_o,
  output logic             caps_on_o
);

  // Input register
  logic             in_valid_q;
  logic [ByteW-1:0] byte_q;
  logic             advance;
  logic             out_free;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= scan_byte_i;
    end
  end

  // Modifier state
  logic ext_q, ctrl_q, shift_q, alt_q, caps_q;
  logic ext_d, ctrl_d, shift_d, alt_d, caps_d;
  logic [CharW-1:0] char_d;
  logic             unknown_d;

  // Decode of the registered byte
  logic [ByteW-2:0] low7;
  logic             handled;
  logic             up;
  logic [CharW-1:0] rom_ch;

  assign low7    = byte_q[ByteW-2:0];
  assign handled = ext_q ? (byte_q == {1'b0, MkAltL[ByteW-2:0]} ||
                            byte_q == {1'b0, MkCtrlL[ByteW-2:0]})
                         : (byte_q != '0 && byte_q < RomLimit);
  // extended codes never hit a symbol key and have zero ROM entries
  assign up      = (!ext_q && is_symbol_key(byte_q)) ? shift_q : (shift_q ^ caps_q);
  assign rom_ch  = char_lookup(byte_q[IdxW-1:0], up);

  always_comb begin
    ext_d     = ext_q;
    ctrl_d    = ctrl_q;
    shift_d   = shift_q;
    alt_d     = alt_q;
    caps_d    = caps_q;
    char_d    = '0;
    unknown_d = 1'b0;
    if (byte_q == PrefixByte) begin
      ext_d = 1'b1;
    end else begin
      ext_d = 1'b0;
      if (byte_q[ByteW-1]) begin
        // break word: clear the matching modifier
        if (low7 == MkCtrlL[ByteW-2:0]) begin
          ctrl_d = 1'b0;
        end else if (!ext_q && (low7 == MkShiftL[ByteW-2:0] ||
                                low7 == MkShiftR[ByteW-2:0])) begin
          shift_d = 1'b0;
        end else if (low7 == MkAltL[ByteW-2:0]) begin
          alt_d = 1'b0;
        end
      end else if (handled) begin
        char_d = rom_ch;
        if (rom_ch == '0) begin
          if (byte_q == MkCtrlL) begin
            ctrl_d = 1'b1;
          end else if (byte_q == MkShiftL || byte_q == MkShiftR) begin
            shift_d = 1'b1;
          end else if (byte_q == MkAltL) begin
            alt_d = 1'b1;
          end else if (byte_q == MkCaps) begin
            caps_d = !caps_q;
          end
        end
      end else begin
        unknown_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q   <= 1'b0;
      ctrl_q  <= 1'b0;
      shift_q <= 1'b0;
      alt_q   <= 1'b0;
      caps_q  <= 1'b0;
    end else if (advance) begin
      ext_q   <= ext_d;
      ctrl_q  <= ctrl_d;
      shift_q <= shift_d;
      alt_q   <= alt_d;
      caps_q  <= caps_d;
    end
  end

  // Result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      char_code_o    <= char_d;
      char_valid_o   <= (char_d != '0);
      unknown_code_o <= unknown_d;
      ctrl_down_o    <= ctrl_d;
      shift_down_o   <= shift_d;
      alt_down_o     <= alt_d;
      caps_on_o      <= caps_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |-> char_code_o != '0)
    else $error("char_valid with zero character");

  a_char_vs_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(char_valid_o && unknown_code_o))
    else $error("character and unknown flag together");

  a_mods_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ctrl_down_o == ctrl_q && shift_down_o == shift_q &&
                     alt_down_o == alt_q && caps_on_o == caps_q))
    else $error("result modifiers differ from held state");

  a_caps_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !ext_q && byte_q == MkCaps |=> caps_q != $past(caps_q))
    else $error("caps lock make did not toggle");

endmodule

/* dv/ps2_set1_decode_checker.sv */
// Scoreboard for the set 1 scan-code decoder: predicts each result word and compares.
module ps2_set1_decode_checker
  import ps2s1_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [ByteW-1:0] scan_byte_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             char_valid_i,
  input  logic             unknown_code_i,
  input  logic             ctrl_down_i,
  input  logic             shift_down_i,
  input  logic             alt_down_i,
  input  logic             caps_on_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_words_o
);

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             char_valid;
    logic             unknown_code;
    logic             ctrl_down;
    logic             shift_down;
    logic             alt_down;
    logic             caps_on;
  } key_word_t;

  // Character table, one entry per make code 0x00..0x3A; zero marks a modifier key or code 0x00
  localparam logic [CharW-1:0] LowerChar [59] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00
  };
  localparam logic [CharW-1:0] UpperChar [59] = '{
    7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
    7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
    7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00
  };

  // Decoder state mirror
  logic ext_armed;
  logic ctrl_on;
  logic shift_on;
  logic alt_on;
  logic caps_flag;

  key_word_t   expected_words[$];
  int unsigned mismatches;

  // Digits and punctuation take shift alone, caps lock does not apply
  function automatic logic shift_only_key(input logic [ByteW-1:0] code);
    logic hit;
    hit = 1'b0;
    if (code < 8'h0e) begin
      hit = 1'b1;
    end else begin
      case (code)
        8'h1a, 8'h1b, 8'h27, 8'h28, 8'h29, 8'h2b, 8'h33, 8'h34, 8'h35: hit = 1'b1;
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

  // Advances the state mirror by one byte and returns the word it should produce
  function automatic key_word_t decode_scan_byte(input logic [ByteW-1:0] b);
    key_word_t        w;
    logic             was_ext;
    logic             upper;
    logic [ByteW-1:0] key_code;
    w = '0;
    if (b == PrefixByte) begin
      ext_armed = 1'b1;
    end else begin
      was_ext   = ext_armed;
      ext_armed = 1'b0;
      key_code  = {1'b0, b[ByteW-2:0]};
      if (b[ByteW-1]) begin
        // break: release a modifier; shift has no extended form
        if (key_code == MkCtrlL) begin
          ctrl_on = 1'b0;
        end else if (!was_ext && (key_code == MkShiftL || key_code == MkShiftR)) begin
          shift_on = 1'b0;
        end else if (key_code == MkAltL) begin
          alt_on = 1'b0;
        end
      end else if (!was_ext && b != '0 && b < RomLimit) begin
        upper = shift_only_key(b) ? shift_on : (shift_on ^ caps_flag);
        w.char_code = upper ? UpperChar[b[IdxW-1:0]] : LowerChar[b[IdxW-1:0]];
        if (w.char_code == '0) begin
          if (b == MkCtrlL) begin
            ctrl_on = 1'b1;
          end else if (b == MkShiftL || b == MkShiftR) begin
            shift_on = 1'b1;
          end else if (b == MkAltL) begin
            alt_on = 1'b1;
          end else if (b == MkCaps) begin
            caps_flag = ~caps_flag;
          end
        end
      end else if (was_ext && b == MkCtrlL) begin
        ctrl_on = 1'b1;
      end else if (was_ext && b == MkAltL) begin
        alt_on = 1'b1;
      end else begin
        w.unknown_code = 1'b1;
      end
    end
    w.char_valid = (w.char_code != '0);
    w.ctrl_down  = ctrl_on;
    w.shift_down = shift_on;
    w.alt_down   = alt_on;
    w.caps_on    = caps_flag;
    return w;
  endfunction

  function automatic int unsigned field_differs(input string name, input int unsigned want,
                                                input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Predict on every accepted byte, compare on every accepted result word
  always @(posedge clk_i or negedge rst_ni) begin
    key_word_t want;
    if (!rst_ni) begin
      ext_armed  = 1'b0;
      ctrl_on    = 1'b0;
      shift_on   = 1'b0;
      alt_on     = 1'b0;
      caps_flag  = 1'b0;
      mismatches = 0;
      expected_words.delete();
      mismatch_count_o <= 0;
      pending_words_o  <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_words.push_back(decode_scan_byte(scan_byte_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected");
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          mismatches += field_differs("char_code", 32'(want.char_code), 32'(char_code_i));
          mismatches += field_differs("char_valid", 32'(want.char_valid),
                                      32'(char_valid_i));
          mismatches += field_differs("unknown_code", 32'(want.unknown_code),
                                      32'(unknown_code_i));
          mismatches += field_differs("ctrl_down", 32'(want.ctrl_down), 32'(ctrl_down_i));
          mismatches += field_differs("shift_down", 32'(want.shift_down),
                                      32'(shift_down_i));
          mismatches += field_differs("alt_down", 32'(want.alt_down), 32'(alt_down_i));
          mismatches += field_differs("caps_on", 32'(want.caps_on), 32'(caps_on_i));
        end
      end
      mismatch_count_o <= mismatches;
      pending_words_o  <= expected_words.size();
    end
  end

endmodule

/* dv/testbench.sv */
// Testbench top: clock, reset, keyboard byte stimulus, result-side stalls and verdict.
module testbench;
  import ps2s1_pkg::*;

  localparam int unsigned RandomBytes = 1900;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic [ByteW-1:0] scan_byte = '0;
  logic             out_stall = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [CharW-1:0] char_code_o;
  logic             char_valid_o;
  logic             unknown_code_o;
  logic             ctrl_down_o;
  logic             shift_down_o;
  logic             alt_down_o;
  logic             caps_on_o;
  int unsigned      mismatch_count;
  int unsigned      pending_words;

  int unsigned      cycle_count = 0;
  int unsigned      burst_left = 0;
  int unsigned      bytes_sent = 0;
  int unsigned      stall_tick = 0;
  stall_mode_e      stall_mode = StallNone;

  ps2_set1_scancode_decoder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .scan_byte_i    (scan_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .char_code_o    (char_code_o),
    .char_valid_o   (char_valid_o),
    .unknown_code_o (unknown_code_o),
    .ctrl_down_o    (ctrl_down_o),
    .shift_down_o   (shift_down_o),
    .alt_down_o     (alt_down_o),
    .caps_on_o      (caps_on_o)
  );

  ps2_set1_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall_o),
    .scan_byte_i      (scan_byte),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall),
    .char_code_i      (char_code_o),
    .char_valid_i     (char_valid_o),
    .unknown_code_i   (unknown_code_o),
    .ctrl_down_i      (ctrl_down_o),
    .shift_down_i     (shift_down_o),
    .alt_down_i       (alt_down_o),
    .caps_on_i        (caps_on_o),
    .mismatch_count_o (mismatch_count),
    .pending_words_o  (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("ps2_set1_scancode_decoder verification failed");
      $finish;
    end
  end

  // Result-side stall: mode is redrawn whenever the low six bits of stall_tick are zero
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[5:0] == 6'd0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= stall_tick[1];
    endcase
  end

  // Offer one byte, hold it until taken, then maybe end the burst with a gap
  task automatic send_scan_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    in_valid  <= 1'b1;
    scan_byte <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      // occasionally a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every predicted word has come back
  task automatic wait_all_returned();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
  endtask

  task automatic key_tap(input logic [ByteW-1:0] key_code, input logic extended,
                         input logic with_break);
    if (extended) send_scan_byte(PrefixByte);
    send_scan_byte(key_code);
    if (with_break) begin
      if (extended) send_scan_byte(PrefixByte);
      send_scan_byte(key_code | 8'h80);
    end
  endtask

  // Modifier press or release, right-hand ctrl and alt through the prefix
  task automatic modifier_event();
    logic [ByteW-1:0] code;
    logic             extended;
    extended = 1'b0;
    case ($urandom_range(0, 6))
      0: code = MkCtrlL;
      1: code = MkShiftL;
      2: code = MkShiftR;
      3: code = MkAltL;
      4: code = MkCaps;
      5: begin code = MkCtrlL; extended = 1'b1; end
      default: begin code = MkAltL; extended = 1'b1; end
    endcase
    if ($urandom_range(0, 1) == 1) code = code | 8'h80;
    if (extended) send_scan_byte(PrefixByte);
    send_scan_byte(code);
  endtask

  initial begin
    int unsigned pick;
    logic [ByteW-1:0] ext_byte;
    logic             drained_midway;
    drained_midway = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero byte, all-ones break, caps and shift on letters and symbols,
    // repeated prefix, extended modifiers and extended unknowns
    send_scan_byte(8'h00);
    send_scan_byte(8'hff);
    send_scan_byte(8'h01);
    send_scan_byte(MkCaps);
    send_scan_byte(8'h10);
    send_scan_byte(MkShiftL);
    send_scan_byte(8'h10);
    send_scan_byte(8'h02);
    send_scan_byte(MkShiftL | 8'h80);
    send_scan_byte(RomLimit);
    send_scan_byte(8'h7f);
    send_scan_byte(PrefixByte);
    send_scan_byte(PrefixByte);
    send_scan_byte(MkCtrlL);
    key_tap(MkAltL, 1'b1, 1'b1);
    key_tap(MkShiftR, 1'b1, 1'b1);
    send_scan_byte(PrefixByte);
    send_scan_byte(8'h10);
    send_scan_byte(MkCtrlL | 8'h80);
    send_scan_byte(MkAltL);
    send_scan_byte(MkAltL | 8'h80);
    send_scan_byte(MkCaps);
    send_scan_byte(8'h39);
    send_scan_byte(8'h80);
    wait_all_returned();

    // Random: mostly key sequences, some noise
    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        key_tap(8'($urandom_range(1, MkCaps)), 1'b0, $urandom_range(0, 9) < 7);
      end else if (pick < 68) begin
        modifier_event();
      end else if (pick < 78) begin
        ext_byte = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 255))
                 : (($urandom_range(0, 1) == 1) ? MkCtrlL : MkAltL)
                   | 8'($urandom_range(0, 1) << 7);
        send_scan_byte(PrefixByte);
        send_scan_byte(ext_byte);
      end else begin
        send_scan_byte(8'($urandom_range(0, 255)));
      end
      if (!drained_midway && bytes_sent > RandomBytes / 2) begin
        drained_midway = 1'b1;
        wait_all_returned();
      end
    end

    wait_all_returned();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("ps2_set1_scancode_decoder verification clean");
    end else begin
      $display("ps2_set1_scancode_decoder verification failed");
    end
    $finish;
  end

endmodule
